// ----- design/olst_pkg.sv -----
package olst_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VALUE_W    = 32;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_DELETE    = 3'd2,
    FN_SEARCH    = 3'd3,
    FN_LIST      = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_REMOVED   = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4,
    STS_EMPTY     = 3'd5,
    STS_LISTED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS_FRONT,
    CELL_APPEND,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic     capture;
    cell_op_t op;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_t;

endpackage

// ----- design/olst_cell.sv -----
module olst_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  olst_pkg::cell_ctl_t ctl,
  input  olst_pkg::value_t   key,
  input  olst_pkg::value_t   ins_value,
  input  olst_pkg::value_t   left_value,
  input  logic               left_valid,
  input  olst_pkg::value_t   right_value,
  input  logic               right_valid,
  input  olst_pkg::value_t   head_value,
  input  logic               hit_in,
  output olst_pkg::value_t   value,
  output logic               valid,
  output logic               hit_out
);

  olst_pkg::value_t value_r, value_nxt;
  logic             valid_r, valid_nxt;
  logic             match_r;

  assign value   = value_r;
  assign valid   = valid_r;
  assign hit_out = hit_in | match_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    unique case (ctl.op)
      olst_pkg::CELL_INS_FRONT: begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end
      olst_pkg::CELL_APPEND: begin
        if (!valid_r && left_valid) begin
          value_nxt = ins_value;
          valid_nxt = 1'b1;
        end
      end
      olst_pkg::CELL_DELETE: begin
        if (hit_out) begin
          value_nxt = right_value;
          valid_nxt = right_valid;
        end
      end
      olst_pkg::CELL_ROTATE: begin
        if (right_valid) begin
          value_nxt = right_value;
        end else if (valid_r) begin
          value_nxt = head_value;
        end
      end
      default: begin
        value_nxt = value_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (ctl.capture) begin
      match_r <= valid_r && (value_r == key);
    end
  end

endmodule

// ----- design/ordered_list_engine_core.sv -----
// insert, delete and search: request taken in idle, result registered once the output
// is free; no new request until then; every cell compares against the key in parallel
// list: N entries, one a cycle while the output is free, rotated out of the head
// the output register frees the result side; a stalled result holds the engine
// synchronous active-low reset empties the list (all cell valid bits cleared)
module ordered_list_engine_core #(
  parameter int LIST_DEPTH = olst_pkg::LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // item_value[31:0]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  olst_pkg::state_t    state_r, state_nxt;
  olst_pkg::func_t     func_r;
  olst_pkg::value_t    val_r;
  olst_pkg::cell_ctl_t ctl;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;

  logic                out_valid_r, out_valid_nxt;
  olst_pkg::status_t   out_status_r, out_status_nxt;
  olst_pkg::value_t    out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                out_free;
  logic                in_acc;
  logic                full;
  logic                found;

  olst_pkg::value_t    cell_value [LIST_DEPTH];
  logic                cell_valid [LIST_DEPTH];
  logic                cell_hit   [LIST_DEPTH];

  assign in_tready  = (state_r == olst_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign full       = (cnt_r == CNT_W'(LIST_DEPTH));
  assign found      = cell_hit[LIST_DEPTH-1];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  genvar g;
  generate
    for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
      olst_pkg::value_t lv, rv;
      logic             lvld, rvld, hin;
      if (g == 0) begin : g_first
        assign lv   = val_r;
        assign lvld = 1'b1;
        assign hin  = 1'b0;
      end else begin : g_mid
        assign lv   = cell_value[g-1];
        assign lvld = cell_valid[g-1];
        assign hin  = cell_hit[g-1];
      end
      if (g == LIST_DEPTH - 1) begin : g_last
        assign rv   = cell_value[g];
        assign rvld = 1'b0;
      end else begin : g_inner
        assign rv   = cell_value[g+1];
        assign rvld = cell_valid[g+1];
      end
      olst_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .key         (olst_pkg::value_t'(in_tdata)),
        .ins_value   (val_r),
        .left_value  (lv),
        .left_valid  (lvld),
        .right_value (rv),
        .right_valid (rvld),
        .head_value  (cell_value[0]),
        .hit_in      (hin),
        .value       (cell_value[g]),
        .valid       (cell_valid[g]),
        .hit_out     (cell_hit[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    ctl.capture    = in_acc;
    ctl.op         = olst_pkg::CELL_HOLD;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      olst_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser <= olst_pkg::FN_LIST)) begin
          state_nxt = olst_pkg::ST_EXEC;
        end
      end
      olst_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt     = olst_pkg::ST_IDLE;
          out_value_nxt = val_r;
          out_last_nxt  = 1'b1;
          unique case (func_r) inside
            olst_pkg::FN_INS_FRONT, olst_pkg::FN_INS_BACK: begin
              out_load = 1'b1;
              if (full) begin
                out_status_nxt = olst_pkg::STS_FULL;
              end else begin
                out_status_nxt = olst_pkg::STS_INSERTED;
                cnt_nxt        = cnt_r + CNT_W'(1);
                ctl.op         = (func_r == olst_pkg::FN_INS_FRONT) ?
                                 olst_pkg::CELL_INS_FRONT : olst_pkg::CELL_APPEND;
              end
            end
            olst_pkg::FN_DELETE: begin
              out_load = 1'b1;
              if (found) begin
                out_status_nxt = olst_pkg::STS_REMOVED;
                cnt_nxt        = cnt_r - CNT_W'(1);
                ctl.op         = olst_pkg::CELL_DELETE;
              end else begin
                out_status_nxt = olst_pkg::STS_NOT_FOUND;
              end
            end
            olst_pkg::FN_SEARCH: begin
              out_load       = 1'b1;
              out_status_nxt = found ? olst_pkg::STS_FOUND : olst_pkg::STS_NOT_FOUND;
            end
            olst_pkg::FN_LIST: begin
              if (cnt_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = olst_pkg::STS_EMPTY;
                out_value_nxt  = '0;
              end else begin
                rem_nxt   = cnt_r;
                state_nxt = olst_pkg::ST_LIST;
              end
            end
            default: begin
              state_nxt = olst_pkg::ST_IDLE;
            end
          endcase
        end
      end
      olst_pkg::ST_LIST: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = olst_pkg::STS_LISTED;
          out_value_nxt  = cell_value[0];
          out_last_nxt   = (rem_r == CNT_W'(1));
          ctl.op         = olst_pkg::CELL_ROTATE;
          rem_nxt        = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = olst_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = olst_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olst_pkg::ST_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= olst_pkg::func_t'(in_tuser);
      val_r  <= olst_pkg::value_t'(in_tdata);
    end
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
